// File: rtl/pli_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the positional list insert and locate core
// no dependencies

package pli_pkg;

    localparam int CAPACITY  = 32;
    localparam int POS_W     = 6;
    localparam int VAL_W     = 32;
    localparam int OUT_CNT_W = 6;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int EXT_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_GET    = 2'd1,
        MODE_LOCATE = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    // controller to datapath
    typedef struct packed {
        logic latch_req;
        logic exec_commit;
        logic match_load;
        logic find_commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        mode_t mode;
    } stat_t;

endpackage

// File: rtl/pli_ctrl.sv
`timescale 1ns / 1ps
// request sequencer: input handshake, step control and result word valid
// depends on pli_pkg

module pli_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  pli_pkg::stat_t stat,
    output pli_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIND
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_req = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.mode == pli_pkg::MODE_LOCATE) begin
                    cmd.match_load = 1'b1;
                    state_next     = ST_FIND;
                end else if (out_free) begin
                    cmd.exec_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_FIND: begin
                if (out_free) begin
                    cmd.find_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.exec_commit || cmd.find_commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted word did not start execution");

    a_commit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec_commit || cmd.find_commit) |=> out_valid_reg)
        else $error("committed result not presented");

    a_find_after_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.match_load) |=> (state_reg == ST_FIND))
        else $error("match vector loaded without search step");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !(cmd.exec_commit || cmd.find_commit))
        else $error("result word overwritten before taken");

endmodule

// File: rtl/pli_datapath.sv
`timescale 1ns / 1ps
// list storage, entry count, match vector and result word register
// depends on pli_pkg

module pli_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pli_pkg::cmd_t                 cmd,
    output pli_pkg::stat_t                stat,
    input  logic [1:0]                    in_mode,
    input  logic [pli_pkg::POS_W-1:0]     in_position,
    input  logic signed [pli_pkg::VAL_W-1:0] in_value,
    output logic                          out_status,
    output logic signed [pli_pkg::VAL_W-1:0] out_read_value,
    output logic [pli_pkg::OUT_CNT_W-1:0] out_found_position,
    output logic [pli_pkg::OUT_CNT_W-1:0] out_entry_count,
    output logic                          out_is_empty
);

    localparam int CAP = pli_pkg::CAPACITY;
    localparam int EW  = pli_pkg::EXT_W;

    pli_pkg::mode_t                   req_mode_reg;
    logic [pli_pkg::POS_W-1:0]        req_pos_reg;
    logic signed [pli_pkg::VAL_W-1:0] req_val_reg;

    logic signed [pli_pkg::VAL_W-1:0] entries_reg  [CAP];
    logic signed [pli_pkg::VAL_W-1:0] entries_next [CAP];
    logic [pli_pkg::CNT_W-1:0]        count_reg;
    logic [pli_pkg::CNT_W-1:0]        count_next;
    logic [CAP-1:0]                   match_reg;
    logic [CAP-1:0]                   match_next;

    logic                             status_reg;
    logic                             status_next;
    logic signed [pli_pkg::VAL_W-1:0] rd_reg;
    logic signed [pli_pkg::VAL_W-1:0] rd_next;
    logic [pli_pkg::OUT_CNT_W-1:0]    found_reg;
    logic [pli_pkg::OUT_CNT_W-1:0]    found_next;
    logic [pli_pkg::OUT_CNT_W-1:0]    cnt_out_reg;
    logic [pli_pkg::OUT_CNT_W-1:0]    cnt_out_next;
    logic                             empty_reg;
    logic                             empty_next;

    logic [EW-1:0]                    pos_ext;
    logic [EW-1:0]                    pidx_ext;
    logic [EW-1:0]                    count_ext;
    logic [EW-1:0]                    count_next_ext;
    logic [EW-1:0]                    found_ext;
    logic [pli_pkg::IDX_W-1:0]        pidx;
    logic                             ins_ok;
    logic                             get_ok;

    assign stat.mode = req_mode_reg;

    assign pos_ext        = {{(EW - pli_pkg::POS_W){1'b0}}, req_pos_reg};
    assign pidx_ext       = pos_ext - EW'(1);
    assign pidx           = pidx_ext[pli_pkg::IDX_W-1:0];
    assign count_ext      = {{(EW - pli_pkg::CNT_W){1'b0}}, count_reg};
    assign count_next_ext = {{(EW - pli_pkg::CNT_W){1'b0}}, count_next};

    assign ins_ok = (count_ext < EW'(CAP)) && (pos_ext != '0) &&
                    (pos_ext <= count_ext + EW'(1));
    assign get_ok = (pos_ext != '0) && (pos_ext <= count_ext);

    // lowest matching slot wins
    always_comb begin
        found_ext = '0;
        for (int k = CAP - 1; k >= 0; k--) begin
            if (match_reg[k]) begin
                found_ext = EW'(k + 1);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < CAP; k++) begin
            match_next[k] = (entries_reg[k] == req_val_reg) && (EW'(k) < count_ext);
        end
    end

    always_comb begin
        entries_next = entries_reg;
        count_next   = count_reg;
        status_next  = pli_pkg::STATUS_OK;
        rd_next      = '0;
        found_next   = '0;
        if (cmd.exec_commit) begin
            case (req_mode_reg)
                pli_pkg::MODE_INSERT: begin
                    if (ins_ok) begin
                        for (int k = 1; k < CAP; k++) begin
                            if (EW'(k) > pidx_ext) begin
                                entries_next[k] = entries_reg[k-1];
                            end
                        end
                        entries_next[pidx] = req_val_reg;
                        count_next         = count_reg + pli_pkg::CNT_W'(1);
                    end else begin
                        status_next = pli_pkg::STATUS_ERR;
                    end
                end
                pli_pkg::MODE_GET: begin
                    if (get_ok) begin
                        rd_next = entries_reg[pidx];
                    end else begin
                        status_next = pli_pkg::STATUS_ERR;
                    end
                end
                pli_pkg::MODE_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                    status_next = pli_pkg::STATUS_OK;
                end
            endcase
        end else if (cmd.find_commit) begin
            found_next = found_ext[pli_pkg::OUT_CNT_W-1:0];
        end
        cnt_out_next = count_next_ext[pli_pkg::OUT_CNT_W-1:0];
        empty_next   = (count_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            req_mode_reg <= pli_pkg::mode_t'(in_mode);
            req_pos_reg  <= in_position;
            req_val_reg  <= in_value;
        end
        if (cmd.exec_commit) begin
            entries_reg <= entries_next;
        end
        if (cmd.match_load) begin
            match_reg <= match_next;
        end
        if (cmd.exec_commit || cmd.find_commit) begin
            status_reg  <= status_next;
            rd_reg      <= rd_next;
            found_reg   <= found_next;
            cnt_out_reg <= cnt_out_next;
            empty_reg   <= empty_next;
        end
    end

    assign out_status         = status_reg;
    assign out_read_value     = rd_reg;
    assign out_found_position = found_reg;
    assign out_entry_count    = cnt_out_reg;
    assign out_is_empty       = empty_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_ext <= EW'(CAP))
        else $error("entry count beyond capacity");

endmodule

// File: rtl/positional_list_insert_locate_core.sv
`timescale 1ns / 1ps
// top level of the positional list insert and locate core
// depends on pli_pkg, pli_ctrl and pli_datapath

// Ordered list of up to 32 signed 32-bit entries held in registers, with insert
// before a 1-based position, get by position, locate of the first equal entry and
// clear. Every request word yields one result word. Insert, get and clear are
// done from the latched request in the execute step; locate compares all entries
// in parallel into a registered match vector and then picks the lowest match in
// the find step. A new request is taken in the cycle after the previous result
// has been placed in the output register, so at most one request is in work at
// a time. No clearing pass after reset.

module positional_list_insert_locate_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // position[5:0], value[37:6], zeros
    input  logic [1:0]  s_tuser,  // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // status[0], read_value[32:1], found_position[38:33],
                                  // entry_count[44:39], is_empty[45], zeros
);

    pli_pkg::cmd_t  cmd;
    pli_pkg::stat_t stat;

    logic                                status;
    logic signed [pli_pkg::VAL_W-1:0]    read_value;
    logic [pli_pkg::OUT_CNT_W-1:0]       found_position;
    logic [pli_pkg::OUT_CNT_W-1:0]       entry_count;
    logic                                is_empty;

    pli_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pli_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .in_mode            (s_tuser),
        .in_position        (s_tdata[5:0]),
        .in_value           (s_tdata[37:6]),
        .out_status         (status),
        .out_read_value     (read_value),
        .out_found_position (found_position),
        .out_entry_count    (entry_count),
        .out_is_empty       (is_empty)
    );

    assign m_tdata = {2'b00, is_empty, entry_count, found_position, read_value, status};

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for positional_list_insert_locate_core: random and directed list requests
// with a shadow list predicting every result word; depends on pli_pkg and the core

module testbench;

    typedef struct {
        pli_pkg::mode_t mode;
        logic [5:0]     pos;
        logic [31:0]    val;
        int             gap;
        bit             drain;
    } list_req_t;

    typedef struct packed {
        logic        status;
        logic [31:0] read_value;
        logic [5:0]  found_pos;
        logic [5:0]  count;
        logic        empty;
    } list_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // position[5:0], value[37:6], zeros
    logic [1:0]  s_tuser = '0;   // mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // status[0], read_value[32:1], found_position[38:33],
                                 // entry_count[44:39], is_empty[45], zeros

    list_req_t    requests_pending[$];
    list_result_t results_due[$];
    list_req_t    cur_req;
    int           n_sent = 0;
    int           n_checked = 0;
    int           mismatches = 0;
    int           idle_cycles = 0;
    int           stall_left = 0;
    bit           rx_quiet = 0;

    // shadow copy of the list
    logic [31:0]  shadow_slots[pli_pkg::CAPACITY];
    int           shadow_fill = 0;
    int           n_by_mode[4];
    int           n_refused = 0;
    int           n_full_refused = 0;
    int           n_found = 0;
    int           peak_fill = 0;

    // stimulus side mirror of the count
    int           gen_fill = 0;
    bit           tx_quiet = 0;
    int           n_queued = 0;
    logic [31:0]  pool[6];

    positional_list_insert_locate_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 0;
    end

    function automatic list_result_t list_apply(list_req_t r);
        list_result_t res;
        int           k;
        res = '0;
        res.status = pli_pkg::STATUS_OK;
        n_by_mode[r.mode]++;
        case (r.mode)
            pli_pkg::MODE_INSERT: begin
                if (shadow_fill >= pli_pkg::CAPACITY || r.pos < 1 ||
                    r.pos > shadow_fill + 1) begin
                    res.status = pli_pkg::STATUS_ERR;
                    if (shadow_fill >= pli_pkg::CAPACITY) n_full_refused++;
                end else begin
                    for (k = shadow_fill; k >= r.pos; k--)
                        shadow_slots[k] = shadow_slots[k - 1];
                    shadow_slots[r.pos - 1] = r.val;
                    shadow_fill++;
                    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
                end
            end
            pli_pkg::MODE_GET: begin
                if (r.pos < 1 || r.pos > shadow_fill)
                    res.status = pli_pkg::STATUS_ERR;
                else
                    res.read_value = shadow_slots[r.pos - 1];
            end
            pli_pkg::MODE_LOCATE: begin
                for (k = 0; k < shadow_fill; k++) begin
                    if (shadow_slots[k] == r.val) begin
                        res.found_pos = k + 1;
                        n_found++;
                        break;
                    end
                end
            end
            default: shadow_fill = 0;
        endcase
        if (res.status == pli_pkg::STATUS_ERR) n_refused++;
        res.count = shadow_fill[5:0];
        res.empty = (shadow_fill == 0);
        return res;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    task automatic queue_request(pli_pkg::mode_t mode, logic [5:0] pos, logic [31:0] val);
        list_req_t r;
        if ($urandom_range(0, 29) == 0) tx_quiet = !tx_quiet;
        r.mode  = mode;
        r.pos   = pos;
        r.val   = val;
        r.gap   = tx_quiet ? 0 : $urandom_range(0, 18);
        r.drain = (n_queued == 25) || ($urandom_range(0, 79) == 0);
        requests_pending.push_back(r);
        n_queued++;
        if (mode == pli_pkg::MODE_INSERT && gen_fill < pli_pkg::CAPACITY && pos >= 1 &&
            pos <= gen_fill + 1)
            gen_fill++;
        else if (mode == pli_pkg::MODE_CLEAR)
            gen_fill = 0;
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    // sender
    always @(posedge aclk) begin : tx_drive
        logic busy;
        logic launch;
        int   sent_now;
        launch   = 1'b0;
        busy     = s_tvalid && !s_tready;
        sent_now = n_sent;
        if (!aresetn) begin
            busy = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                results_due.push_back(list_apply(cur_req));
                sent_now = n_sent + 1;
                n_sent <= sent_now;
            end
            if (!busy && requests_pending.size() > 0) begin
                if (idle_cycles < requests_pending[0].gap) begin
                    idle_cycles++;
                end else if (!requests_pending[0].drain || sent_now == n_checked) begin
                    cur_req = requests_pending.pop_front();
                    idle_cycles = 0;
                    launch = 1'b1;
                    s_tdata <= {2'b00, cur_req.val, cur_req.pos};
                    s_tuser <= cur_req.mode;
                end
            end
        end
        s_tvalid <= launch || busy;
    end

    // receiver and checker
    always @(posedge aclk) begin : rx_check
        list_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result word expected none got %h", $time, m_tdata);
                end else begin
                    want = results_due.pop_front();
                    n_checked <= n_checked + 1;
                    compare_field("status", want.status, m_tdata[0]);
                    compare_field("read_value", want.read_value, m_tdata[32:1]);
                    compare_field("found_position", want.found_pos, m_tdata[38:33]);
                    compare_field("entry_count", want.count, m_tdata[44:39]);
                    compare_field("is_empty", want.empty, m_tdata[45]);
                end
                if ($urandom_range(0, 29) == 0) rx_quiet = !rx_quiet;
                stall_left = rx_quiet ? 0 : $urandom_range(0, 18);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_tready <= (stall_left == 0);
        end
    end

    initial begin : stimulus
        int ep_len;
        int pick;
        int n_random;

        // directed: empty list, bad positions, extremes, stale entries after clear
        queue_request(pli_pkg::MODE_GET, 6'd1, 32'h0000_0001);
        queue_request(pli_pkg::MODE_LOCATE, 6'd0, 32'h0000_0000);
        queue_request(pli_pkg::MODE_INSERT, 6'd0, 32'h1234_5678);
        queue_request(pli_pkg::MODE_INSERT, 6'd2, 32'h1234_5678);
        queue_request(pli_pkg::MODE_INSERT, 6'd1, 32'h7fff_ffff);
        queue_request(pli_pkg::MODE_INSERT, 6'd1, 32'h8000_0000);
        queue_request(pli_pkg::MODE_INSERT, 6'd3, 32'hffff_ffff);
        queue_request(pli_pkg::MODE_INSERT, 6'd2, 32'h0000_0000);
        queue_request(pli_pkg::MODE_INSERT, 6'd63, 32'h5555_aaaa);
        queue_request(pli_pkg::MODE_GET, 6'd0, 32'h0);
        queue_request(pli_pkg::MODE_GET, 6'd1, 32'h0);
        queue_request(pli_pkg::MODE_GET, 6'd2, 32'h0);
        queue_request(pli_pkg::MODE_GET, 6'd3, 32'h0);
        queue_request(pli_pkg::MODE_GET, 6'd4, 32'h0);
        queue_request(pli_pkg::MODE_GET, 6'd5, 32'h0);
        queue_request(pli_pkg::MODE_GET, 6'd63, 32'h0);
        queue_request(pli_pkg::MODE_LOCATE, 6'd0, 32'hffff_ffff);
        queue_request(pli_pkg::MODE_LOCATE, 6'd63, 32'h8000_0000);
        queue_request(pli_pkg::MODE_LOCATE, 6'd0, 32'h0000_3039);
        queue_request(pli_pkg::MODE_CLEAR, 6'd63, 32'hffff_ffff);
        queue_request(pli_pkg::MODE_LOCATE, 6'd0, 32'h7fff_ffff);
        queue_request(pli_pkg::MODE_GET, 6'd1, 32'h0);
        queue_request(pli_pkg::MODE_CLEAR, 6'd0, 32'h0);

        // random episodes of mostly well formed traffic, drawn from a small value pool
        n_random = 0;
        while (n_random < 950) begin
            if ($urandom_range(0, 2) != 0) begin
                queue_request(pli_pkg::MODE_CLEAR, $urandom_range(0, 63), $urandom);
                n_random++;
            end
            foreach (pool[i]) begin
                case ($urandom_range(0, 7))
                    0: pool[i] = 32'h8000_0000;
                    1: pool[i] = 32'h7fff_ffff;
                    2: pool[i] = 32'hffff_ffff;
                    3: pool[i] = 32'h0000_0000;
                    default: pool[i] = $urandom;
                endcase
            end
            ep_len = $urandom_range(4, 70);
            repeat (ep_len) begin
                pick = $urandom_range(0, 19);
                if (pick < 10) begin
                    if ($urandom_range(0, 9) == 0)
                        queue_request(pli_pkg::MODE_INSERT, $urandom_range(0, 63),
                                      pick_value());
                    else
                        queue_request(pli_pkg::MODE_INSERT, $urandom_range(1, gen_fill + 1),
                                      pick_value());
                end else if (pick < 14) begin
                    if (gen_fill == 0 || $urandom_range(0, 7) == 0)
                        queue_request(pli_pkg::MODE_GET, $urandom_range(0, 63), $urandom);
                    else
                        queue_request(pli_pkg::MODE_GET, $urandom_range(1, gen_fill), $urandom);
                end else if (pick < 18) begin
                    queue_request(pli_pkg::MODE_LOCATE, $urandom_range(0, 63), pick_value());
                end else begin
                    queue_request(pli_pkg::mode_t'($urandom_range(0, 3)),
                                  $urandom_range(0, 63), $urandom);
                end
                n_random++;
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (requests_pending.size() != 0 || s_tvalid || n_sent != n_checked)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (results_due.size() != 0) begin
            mismatches++;
            $display("%0t ns: %0d result words never arrived", $time, results_due.size());
        end
        $display("covered %0d inserts, %0d gets, %0d locates, %0d clears; %0d refused",
                 n_by_mode[pli_pkg::MODE_INSERT], n_by_mode[pli_pkg::MODE_GET],
                 n_by_mode[pli_pkg::MODE_LOCATE], n_by_mode[pli_pkg::MODE_CLEAR], n_refused);
        $display("list peaked at %0d entries, %0d inserts refused when full, %0d matches found",
                 peak_fill, n_full_refused, n_found);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("watchdog expired at %0t ns", $time);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
rtl/pli_pkg.sv
rtl/pli_ctrl.sv
rtl/pli_datapath.sv
rtl/positional_list_insert_locate_core.sv
bench/testbench.sv
